>>> design/gmps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Maze solver package
// Shared widths, cell and direction codes, and the word types of both ports.
// ----------------------------------------------------------------------------
package gmps_pkg;

  localparam int DEF_ROWS = 5;
  localparam int DEF_COLS = 5;

  localparam int COORD_W = 3;
  localparam int KIND_W  = 2;
  localparam int OKIND_W = 3;
  localparam int DIR_W   = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXIT  = 2'd3;

  localparam logic [OKIND_W-1:0] OUT_KIND_OPEN = 3'd0;
  localparam logic [OKIND_W-1:0] OUT_KIND_PATH = 3'd4;

  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [KIND_W-1:0]  cell_kind;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [OKIND_W-1:0] out_kind;
    logic               found;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

>>> design/grid_maze_path_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maze path search
// Depth-first maze solver with an explicit stack over a ROWS x COLS grid.
// ----------------------------------------------------------------------------
// A load word leaves busy low, so loads run one per cycle.
// A solve word holds busy high: the start scan reads, then checks each cell; each
// search move skips a neighbour outside the grid or reads the grid, then checks it;
// each back-out reads the stack; and the report reads each cell, then sends one word.
// The one grid RAM read port, shared by scan, search and report, paces these steps.
// Reset returns the sequencer to idle; the grid contents are undefined until loaded.
module grid_maze_path_search import gmps_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output result_t result,
  output logic    result_strobe
);

  localparam int NCELLS  = ROWS * COLS;
  localparam int CELL_W  = $clog2(NCELLS);
  localparam int DEPTH_W = $clog2(NCELLS + 1);

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CELL_W-1:0]  idx;
    logic [DIR_W-1:0]   dir;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CHK = 8'b0000_0100,
    S_STEP     = 8'b0000_1000,
    S_NB_CHK   = 8'b0001_0000,
    S_POP_LD   = 8'b0010_0000,
    S_EMIT_RD  = 8'b0100_0000,
    S_EMIT_OUT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [COORD_W-1:0] pos_row, pos_col, cur_row, cur_col, nb_row, nb_col;
  logic [CELL_W-1:0]  pos_idx, cur_idx, nb_idx;
  logic [DIR_W-1:0]   cur_dir;
  logic [DEPTH_W-1:0] depth;
  logic [NCELLS-1:0]  visited, path_mark;

  logic               accept, load_ok, solve_go, pos_end, push_ok, strobe_next;
  logic [CELL_W-1:0]  load_idx, grid_raddr;
  logic [KIND_W-1:0]  grid_rdata;
  logic [DEPTH_W-1:0] depth_m1, depth_m2;
  entry_t             push_entry, pop_entry;
  logic [ENTRY_W-1:0] stack_rdata;

  // Neighbour for the current direction.
  logic               nb_in;
  logic [COORD_W-1:0] nr, nc;
  logic [CELL_W-1:0]  ni;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign load_ok  = accept && (item.operation == OP_LOAD)
                    && ({1'b0, item.row} < 4'(ROWS)) && ({1'b0, item.col} < 4'(COLS));
  assign solve_go = accept && (item.operation == OP_SOLVE);
  assign load_idx = CELL_W'(item.row) * CELL_W'(COLS) + CELL_W'(item.col);
  assign pos_end  = (pos_idx == CELL_W'(NCELLS - 1));
  assign depth_m1 = depth - DEPTH_W'(1);
  assign depth_m2 = depth - DEPTH_W'(2);
  assign push_ok  = (grid_rdata != KIND_WALL) && !visited[nb_idx]
                    && (depth < DEPTH_W'(NCELLS));
  assign pop_entry = entry_t'(stack_rdata);

  // A word goes out on a failed scan, on backing out of the start cell, and in
  // every report cycle.
  assign strobe_next = ((state == S_SCAN_CHK) && (grid_rdata != KIND_START) && pos_end)
                       || ((state == S_STEP) && (cur_dir == DIR_DONE)
                           && (depth == DEPTH_W'(1)))
                       || (state == S_EMIT_OUT);

  always_comb begin
    nb_in = 1'b0;
    nr    = cur_row;
    nc    = cur_col;
    ni    = cur_idx;
    case (cur_dir)
      DIR_DOWN: begin
        nb_in = (cur_row != COORD_W'(ROWS - 1));
        nr    = cur_row + COORD_W'(1);
        ni    = cur_idx + CELL_W'(COLS);
      end
      DIR_RIGHT: begin
        nb_in = (cur_col != COORD_W'(COLS - 1));
        nc    = cur_col + COORD_W'(1);
        ni    = cur_idx + CELL_W'(1);
      end
      DIR_UP: begin
        nb_in = (cur_row != '0);
        nr    = cur_row - COORD_W'(1);
        ni    = cur_idx - CELL_W'(COLS);
      end
      DIR_LEFT: begin
        nb_in = (cur_col != '0);
        nc    = cur_col - COORD_W'(1);
        ni    = cur_idx - CELL_W'(1);
      end
      default: begin
        nb_in = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_STEP:  grid_raddr = ni;
      default: grid_raddr = pos_idx;
    endcase
  end

  assign push_entry = '{row: cur_row, col: cur_col, idx: cur_idx, dir: cur_dir};

  gmps_ram #(
    .WIDTH (KIND_W),
    .DEPTH (NCELLS)
  ) u_grid (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_idx),
    .wdata (item.cell_kind),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // The stack RAM holds every entry below the top; the top lives in cur_*.
  gmps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NCELLS)
  ) u_stack (
    .clk   (clk),
    .we    ((state == S_NB_CHK) && (grid_rdata != KIND_EXIT) && push_ok),
    .waddr (depth_m1[CELL_W-1:0]),
    .wdata (push_entry),
    .raddr (depth_m2[CELL_W-1:0]),
    .rdata (stack_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (solve_go) state_next = S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (grid_rdata == KIND_START) begin
          state_next = S_STEP;
        end else if (pos_end) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_STEP: begin
        if (cur_dir == DIR_DONE) begin
          state_next = (depth == DEPTH_W'(1)) ? S_IDLE : S_POP_LD;
        end else if (nb_in) begin
          state_next = S_NB_CHK;
        end
      end
      S_NB_CHK:   state_next = (grid_rdata == KIND_EXIT) ? S_EMIT_RD : S_STEP;
      S_POP_LD:   state_next = S_STEP;
      S_EMIT_RD:  state_next = S_EMIT_OUT;
      S_EMIT_OUT: state_next = pos_end ? S_IDLE : S_EMIT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      depth         <= '0;
      visited       <= '0;
      path_mark     <= '0;
    end else begin
      state         <= state_next;
      result_strobe <= strobe_next;
      case (state)
        S_IDLE: begin
          if (solve_go) begin
            visited   <= '0;
            path_mark <= '0;
            depth     <= '0;
            pos_row   <= '0;
            pos_col   <= '0;
            pos_idx   <= '0;
          end
        end
        S_SCAN_CHK: begin
          if (grid_rdata == KIND_START) begin
            cur_row          <= pos_row;
            cur_col          <= pos_col;
            cur_idx          <= pos_idx;
            cur_dir          <= DIR_DOWN;
            depth            <= DEPTH_W'(1);
            visited[pos_idx] <= 1'b1;
          end else if (pos_end) begin
            result        <= '{out_row: '0, out_col: '0, out_kind: OUT_KIND_OPEN,
                               found: 1'b0, last: 1'b1};
          end else if (pos_col == COORD_W'(COLS - 1)) begin
            pos_col <= '0;
            pos_row <= pos_row + COORD_W'(1);
            pos_idx <= pos_idx + CELL_W'(1);
          end else begin
            pos_col <= pos_col + COORD_W'(1);
            pos_idx <= pos_idx + CELL_W'(1);
          end
        end
        S_STEP: begin
          if (cur_dir == DIR_DONE) begin
            // Backing out: the cell leaves the path but stays visited.
            path_mark[cur_idx] <= 1'b0;
            depth              <= depth_m1;
            if (depth == DEPTH_W'(1)) begin
              result        <= '{out_row: '0, out_col: '0, out_kind: OUT_KIND_OPEN,
                                 found: 1'b0, last: 1'b1};
            end
          end else begin
            cur_dir <= cur_dir + DIR_W'(1);
            nb_row  <= nr;
            nb_col  <= nc;
            nb_idx  <= ni;
          end
        end
        S_NB_CHK: begin
          if (grid_rdata == KIND_EXIT) begin
            pos_row <= '0;
            pos_col <= '0;
            pos_idx <= '0;
          end else if (push_ok) begin
            visited[nb_idx]   <= 1'b1;
            path_mark[nb_idx] <= 1'b1;
            cur_row           <= nb_row;
            cur_col           <= nb_col;
            cur_idx           <= nb_idx;
            cur_dir           <= DIR_DOWN;
            depth             <= depth + DEPTH_W'(1);
          end
        end
        S_POP_LD: begin
          cur_row <= pop_entry.row;
          cur_col <= pop_entry.col;
          cur_idx <= pop_entry.idx;
          cur_dir <= pop_entry.dir;
        end
        S_EMIT_OUT: begin
          result.out_row  <= pos_row;
          result.out_col  <= pos_col;
          result.out_kind <= path_mark[pos_idx] ? OUT_KIND_PATH : {1'b0, grid_rdata};
          result.found    <= 1'b1;
          result.last     <= pos_end;
          if (pos_col == COORD_W'(COLS - 1)) begin
            pos_col <= '0;
            pos_row <= pos_row + COORD_W'(1);
          end else begin
            pos_col <= pos_col + COORD_W'(1);
          end
          pos_idx <= pos_idx + CELL_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // The search stack never grows beyond the number of cells.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(NCELLS))
    else $error("search stack deeper than the grid");

  // A cell can only be on the path once it has been visited.
  a_path_visited: assert property (@(posedge clk) disable iff (rst)
    (path_mark & ~visited) == '0)
    else $error("path cell not marked visited");

  // While searching the stack holds at least the start cell.
  a_depth_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP || state == S_NB_CHK) |-> depth != '0)
    else $error("search running on an empty stack");

  // A not-found word always closes the run.
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.found) |-> result.last)
    else $error("not-found word without last");

  // The last word of a run is followed by a quiet cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |=> !result_strobe)
    else $error("word emitted straight after the last one");

endmodule

`default_nettype wire

>>> design/gmps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> dv/grid_maze_path_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maze path search testbench
// Loads cells into the maze, runs solves and compares every reported word
// with a depth-first predictor kept alongside the block, then checks random
// mazes built from loads, noise loads outside the grid and solves.
// ----------------------------------------------------------------------------
module grid_maze_path_search_tb;
  import gmps_pkg::*;

  localparam int MAZE_ROWS   = DEF_ROWS;
  localparam int MAZE_COLS   = DEF_COLS;
  localparam int MAZE_CELLS  = MAZE_ROWS * MAZE_COLS;
  localparam int ITEM_TARGET = 280;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN       = 20;

  localparam result_t NOT_FOUND = '{out_row: '0, out_col: '0, out_kind: OUT_KIND_OPEN,
                                    found: 1'b0, last: 1'b1};

  typedef struct {
    item_t word;
    bit    typed;
  } plan_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  result_t result;
  logic    result_strobe;

  logic [KIND_W-1:0] maze_cells [MAZE_CELLS];
  result_t           expected_words [$];
  plan_row_t         test_plan [$];
  int                errors;
  int                stall_cycles;

  grid_maze_path_search #(.ROWS(MAZE_ROWS), .COLS(MAZE_COLS)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic item_t make_word(input logic op, input int r, input int c,
                                      input logic [KIND_W-1:0] k);
    item_t w;
    w.operation = op;
    w.row       = r[COORD_W-1:0];
    w.col       = c[COORD_W-1:0];
    w.cell_kind = k;
    return w;
  endfunction

  // Depth-first walk of the maze as the block should do it, trying down, right,
  // up and left in turn. A cell stays visited after the search backs out of it.
  task automatic solve_maze();
    int      stk [MAZE_CELLS];
    int      dir [MAZE_CELLS];
    bit      seen [MAZE_CELLS];
    bit      on_path [MAZE_CELLS];
    int      depth;
    int      origin;
    int      spot;
    int      nr;
    int      nc;
    int      n;
    int      d;
    bit      hit;
    result_t w;
    origin = -1;
    hit    = 1'b0;
    depth  = 0;
    foreach (seen[i]) begin
      seen[i]    = 1'b0;
      on_path[i] = 1'b0;
    end
    for (int i = 0; i < MAZE_CELLS; i++) begin
      if (maze_cells[i] == KIND_START) begin
        origin = i;
        break;
      end
    end
    if (origin >= 0) begin
      seen[origin] = 1'b1;
      stk[0]       = origin;
      dir[0]       = DIR_DOWN;
      depth        = 1;
    end
    while (depth > 0 && !hit) begin
      spot = stk[depth-1];
      d    = dir[depth-1];
      if (d >= DIR_DONE) begin
        depth--;
        continue;
      end
      dir[depth-1] = d + 1;
      nr = spot / MAZE_COLS;
      nc = spot % MAZE_COLS;
      case (d)
        DIR_DOWN:  nr++;
        DIR_RIGHT: nc++;
        DIR_UP:    nr--;
        default:   nc--;
      endcase
      // Bounds come first, so an exit is never looked up outside the grid.
      if (nr < 0 || nc < 0 || nr >= MAZE_ROWS || nc >= MAZE_COLS) continue;
      n = nr * MAZE_COLS + nc;
      if (maze_cells[n] == KIND_EXIT) begin
        hit = 1'b1;
      end else if (maze_cells[n] != KIND_WALL && !seen[n] && depth < MAZE_CELLS) begin
        seen[n]    = 1'b1;
        stk[depth] = n;
        dir[depth] = DIR_DOWN;
        depth++;
      end
    end
    if (!hit) begin
      expected_words.push_back(NOT_FOUND);
    end else begin
      for (int i = 1; i < depth; i++) on_path[stk[i]] = 1'b1;
      for (int i = 0; i < MAZE_CELLS; i++) begin
        w.out_row  = COORD_W'(i / MAZE_COLS);
        w.out_col  = COORD_W'(i % MAZE_COLS);
        w.out_kind = on_path[i] ? OUT_KIND_PATH : {1'b0, maze_cells[i]};
        w.found    = 1'b1;
        w.last     = (i == MAZE_CELLS - 1);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic apply_word(input item_t w);
    if (w.operation == OP_LOAD) begin
      if (w.row < MAZE_ROWS && w.col < MAZE_COLS)
        maze_cells[w.row * MAZE_COLS + w.col] = w.cell_kind;
    end else begin
      solve_maze();
    end
  endtask

  // Called just after a rising edge; returns at the edge that takes the word.
  task automatic send_word(input item_t w, input bit typed);
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) expected_words.push_back(NOT_FOUND);
    else apply_word(w);
  endtask

  task automatic add_row(input logic op, input int r, input int c,
                         input logic [KIND_W-1:0] k, input bit typed);
    plan_row_t p;
    p.word  = make_word(op, r, c, k);
    p.typed = typed;
    test_plan.push_back(p);
  endtask

  function automatic logic [KIND_W-1:0] random_kind();
    int v;
    v = $urandom_range(0, 99);
    if (v < 40) return KIND_OPEN;
    if (v < 70) return KIND_WALL;
    if (v < 82) return KIND_START;
    return KIND_EXIT;
  endfunction

  function automatic item_t random_solve();
    return make_word(OP_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7),
                     KIND_W'($urandom_range(0, 3)));
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %p", result));
      end else begin
        want = expected_words.pop_front();
        if (result.out_row != want.out_row)
          report_mismatch($sformatf("out_row got %0d, expected %0d",
                                    result.out_row, want.out_row));
        if (result.out_col != want.out_col)
          report_mismatch($sformatf("out_col got %0d, expected %0d",
                                    result.out_col, want.out_col));
        if (result.out_kind != want.out_kind)
          report_mismatch($sformatf("out_kind got %0d, expected %0d at (%0d,%0d)",
                                    result.out_kind, want.out_kind,
                                    want.out_row, want.out_col));
        if (result.found != want.found)
          report_mismatch($sformatf("found got %0d, expected %0d",
                                    result.found, want.found));
        if (result.last != want.last)
          report_mismatch($sformatf("last got %0d, expected %0d",
                                    result.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int    counted;
    int    episode;
    int    loads;
    bit    quiet;
    item_t w;
    errors       = 0;
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Every cell is written before the first solve can read it.
    for (int i = 0; i < MAZE_CELLS; i++)
      send_word(make_word(OP_LOAD, i / MAZE_COLS, i % MAZE_COLS, KIND_OPEN), 1'b0);

    add_row(OP_SOLVE, 7, 7, KIND_EXIT,  1'b1);  // no start cell anywhere
    add_row(OP_LOAD,  7, 7, KIND_EXIT,  1'b0);  // outside the grid, ignored
    add_row(OP_LOAD,  0, 5, KIND_EXIT,  1'b0);
    add_row(OP_LOAD,  5, 0, KIND_START, 1'b0);
    add_row(OP_SOLVE, 0, 0, KIND_OPEN,  1'b1);
    add_row(OP_LOAD,  0, 0, KIND_START, 1'b0);
    add_row(OP_SOLVE, 5, 2, KIND_WALL,  1'b1);  // start but no exit
    add_row(OP_LOAD,  4, 4, KIND_EXIT,  1'b0);
    add_row(OP_SOLVE, 0, 0, KIND_OPEN,  1'b0);  // open field, corner to corner
    add_row(OP_LOAD,  0, 1, KIND_WALL,  1'b0);
    add_row(OP_LOAD,  1, 0, KIND_WALL,  1'b0);
    add_row(OP_SOLVE, 2, 7, KIND_START, 1'b1);  // start walled in
    add_row(OP_LOAD,  1, 0, KIND_OPEN,  1'b0);
    add_row(OP_LOAD,  2, 0, KIND_START, 1'b0);  // second start lies on the path
    add_row(OP_SOLVE, 0, 0, KIND_OPEN,  1'b0);
    add_row(OP_LOAD,  0, 0, KIND_OPEN,  1'b0);
    add_row(OP_LOAD,  4, 0, KIND_EXIT,  1'b0);
    add_row(OP_SOLVE, 3, 3, KIND_EXIT,  1'b0);
    add_row(OP_LOAD,  3, 0, KIND_WALL,  1'b0);
    add_row(OP_LOAD,  2, 1, KIND_WALL,  1'b0);
    add_row(OP_LOAD,  1, 0, KIND_WALL,  1'b0);
    add_row(OP_SOLVE, 6, 6, KIND_WALL,  1'b1);  // only way out is off the left edge
    add_row(OP_LOAD,  2, 0, KIND_OPEN,  1'b0);
    add_row(OP_LOAD,  4, 3, KIND_START, 1'b0);
    add_row(OP_SOLVE, 1, 4, KIND_OPEN,  1'b0);  // exit right beside the first start

    foreach (test_plan[i]) send_word(test_plan[i].word, test_plan[i].typed);

    counted = 0;
    episode = 0;
    while (counted < ITEM_TARGET) begin
      // Hold off once in a while so the block drains completely.
      if (episode % 7 == 3) begin
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
      end
      quiet = (counted >= 150 && counted < 230);
      if ($urandom_range(0, 4) == 0) loads = MAZE_CELLS + 2;
      else loads = $urandom_range(1, 8);
      for (int i = 0; i <= loads; i++) begin
        if (i == loads) begin
          w = random_solve();
        end else if (loads > MAZE_CELLS && i < MAZE_CELLS) begin
          w = make_word(OP_LOAD, i / MAZE_COLS, i % MAZE_COLS, random_kind());
        end else if (loads > MAZE_CELLS) begin
          // A fresh maze gets one start and one exit on top of the random fill.
          w = make_word(OP_LOAD, $urandom_range(0, MAZE_ROWS - 1),
                        $urandom_range(0, MAZE_COLS - 1),
                        (i == MAZE_CELLS) ? KIND_START : KIND_EXIT);
        end else begin
          w = make_word(OP_LOAD, $urandom_range(0, MAZE_ROWS - 1),
                        $urandom_range(0, MAZE_COLS - 1), random_kind());
        end
        if (!quiet && $urandom_range(0, 99) < 17) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        // Noise: a load just outside the grid, which the block ignores.
        if (w.operation == OP_LOAD && $urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1))
            send_word(make_word(OP_LOAD, $urandom_range(MAZE_ROWS, 7),
                                $urandom_range(0, 7), random_kind()), 1'b0);
          else
            send_word(make_word(OP_LOAD, $urandom_range(0, 7),
                                $urandom_range(MAZE_COLS, 7), random_kind()), 1'b0);
        end
        send_word(w, 1'b0);
        counted++;
      end
      episode++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
